[rtl/aat_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants and IEEE single-precision helpers (multiply, add, compare)
// for the box transform pipeline. Round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
package aat_pkg;

	typedef logic [31:0] f32_t;

	localparam int AAT_STAGES = 8;

	localparam f32_t F_ONE     = 32'h3F80_0000;
	localparam f32_t F_HALF    = 32'h3F00_0000;
	localparam f32_t F_EPS     = 32'h2B8C_BCCC;
	localparam f32_t F_ZERO    = 32'h0000_0000;
	localparam f32_t F_POS_INF = 32'h7F80_0000;
	localparam f32_t F_NEG_INF = 32'hFF80_0000;
	localparam f32_t F_QNAN    = 32'h7FC0_0000;

	function automatic logic f_isfin(input f32_t a);
		return a[30:23] != 8'hFF;
	endfunction

	function automatic logic f_isnan(input f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic f32_t f_abs(input f32_t a);
		return {1'b0, a[30:0]};
	endfunction

	// Maps a float onto an unsigned key whose order matches the numeric order.
	function automatic logic [31:0] f_key(input f32_t a);
		return a[31] ? ~a : {1'b1, a[30:0]};
	endfunction

	function automatic logic f_le(input f32_t a, input f32_t b);
		if (f_isnan(a) || f_isnan(b))
			return 1'b0;
		if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
			return 1'b1;
		return f_key(a) <= f_key(b);
	endfunction

	function automatic logic f_lt(input f32_t a, input f32_t b);
		if (f_isnan(a) || f_isnan(b))
			return 1'b0;
		if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
			return 1'b0;
		return f_key(a) < f_key(b);
	endfunction

	// The significand m has its leading one at bit 26 (or is below it for a
	// result that is already subnormal); bit 0 is a sticky bit. e is biased.
	function automatic f32_t f_round_pack(input logic s, input logic signed [10:0] e,
			input logic [26:0] m);
		logic signed [10:0] d;
		logic [4:0]  sh;
		logic [26:0] mm;
		logic [26:0] mask;
		logic [7:0]  ee;
		logic        up;
		mm   = m;
		ee   = 8'd0;
		d    = 11'sd0;
		sh   = 5'd0;
		mask = 27'd0;
		if (e >= 11'sd255)
			return {s, 8'hFF, 23'd0};
		if (e <= 11'sd0) begin
			d = 11'sd1 - e;
			if (d > 11'sd26)
				d = 11'sd26;
			sh   = d[4:0];
			mask = (27'd1 << sh) - 27'd1;
			mm   = (m >> sh) | {26'd0, |(m & mask)};
		end else begin
			ee = e[7:0];
		end
		up = mm[2] & (mm[3] | mm[1] | mm[0]);
		// A carry out of the fraction moves into the exponent, which also
		// covers rounding up to the smallest normal or to infinity.
		return {s, ee, mm[25:3]} + {31'd0, up};
	endfunction

	function automatic f32_t f_mul(input f32_t a, input f32_t b);
		logic        s;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [47:0] p;
		logic [47:0] pn;
		logic [5:0]  lz;
		logic signed [10:0] e;
		s  = a[31] ^ b[31];
		lz = 6'd0;
		if (f_isnan(a) || f_isnan(b))
			return F_QNAN;
		if (!f_isfin(a) || !f_isfin(b)) begin
			if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0))
				return F_QNAN;
			return {s, 8'hFF, 23'd0};
		end
		if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0))
			return {s, 31'd0};
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p  = ma * mb;
		for (int i = 0; i < 48; i++) begin
			if (p[i])
				lz = 6'(47 - i);
		end
		pn = p << lz;
		e  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
			- $signed({5'b00000, lz});
		return f_round_pack(s, e, {pn[47:22], |pn[21:0]});
	endfunction

	function automatic f32_t f_add(input f32_t a, input f32_t b);
		f32_t        x;
		f32_t        y;
		logic [23:0] mx;
		logic [23:0] my;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [7:0]  d;
		logic [26:0] by0;
		logic [26:0] bs;
		logic [26:0] mask;
		logic [27:0] sum;
		logic [26:0] m;
		logic [4:0]  lz;
		logic        sub;
		logic signed [10:0] e;
		lz = 5'd0;
		if (f_isnan(a) || f_isnan(b))
			return F_QNAN;
		if (!f_isfin(a) && !f_isfin(b) && (a[31] != b[31]))
			return F_QNAN;
		if (!f_isfin(a))
			return a;
		if (!f_isfin(b))
			return b;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		mx  = {x[30:23] != 8'd0, x[22:0]};
		my  = {y[30:23] != 8'd0, y[22:0]};
		ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d   = ex - ey;
		by0 = {my, 3'b000};
		if (d > 8'd26) begin
			bs = {26'd0, |by0};
		end else begin
			mask = (27'd1 << d) - 27'd1;
			bs   = (by0 >> d) | {26'd0, |(by0 & mask)};
		end
		sub = x[31] ^ y[31];
		if (sub)
			sum = {1'b0, mx, 3'b000} - {1'b0, bs};
		else
			sum = {1'b0, mx, 3'b000} + {1'b0, bs};
		if (sum == 28'd0)
			return sub ? F_ZERO : {x[31], 31'd0};
		if (sum[27]) begin
			m = {sum[27:2], sum[1] | sum[0]};
			e = $signed({3'b000, ex}) + 11'sd1;
		end else begin
			for (int i = 0; i < 27; i++) begin
				if (sum[i])
					lz = 5'(26 - i);
			end
			m = sum[26:0] << lz;
			e = $signed({3'b000, ex}) - $signed({6'b000000, lz});
		end
		return f_round_pack(x[31], e, m);
	endfunction

	function automatic f32_t f_sub(input f32_t a, input f32_t b);
		return f_add(a, {~b[31], b[30:0]});
	endfunction

endpackage
`default_nettype wire

[rtl/aat_pipe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pipe_ctrl
// Per-stage load enables for a pipeline whose bubbles close up: a stage takes
// new contents when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module aat_pipe_ctrl #(
	parameter int Stages = aat_pkg::AAT_STAGES
) (
	input  wire logic [Stages-1:0] stage_vld,
	input  wire logic              out_stall,
	output logic      [Stages-1:0] load
);
	import aat_pkg::*;

	always_comb begin
		load[Stages-1] = !stage_vld[Stages-1] || !out_stall;
		for (int k = Stages - 2; k >= 0; k--) begin
			load[k] = !stage_vld[k] || load[k+1];
		end
	end

endmodule
`default_nettype wire

[rtl/aabb_affine_transform.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Throughput: one item per cycle while the output is not stalled; every stage
// holds one single-precision operation per lane, so a new item can enter in
// each cycle that the pipeline is not held, and the chain of center/extent
// sums sets the depth of eight stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// World-space bounds of an affine-transformed box by the center/extent method.
// Stage 1 halves the box corners and starts the bottom-row affine test. Stage
// 2 forms local center and extent, stage 3 the eighteen matrix products, and
// stages 4 to 6 accumulate center and extent in column order. Stage 7 forms
// the world corners and finishes the affine test, and the output stage applies
// all validity checks, replacing an invalid result with the empty box.
// A stalled output only holds the stages that are full, so empty slots in the
// pipeline keep filling while a result waits.
// ----------------------------------------------------------------------------
module aabb_affine_transform (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] col0_rows01,
	input  wire logic [63:0] col0_rows23,
	input  wire logic [63:0] col1_rows01,
	input  wire logic [63:0] col1_rows23,
	input  wire logic [63:0] col2_rows01,
	input  wire logic [63:0] col2_rows23,
	input  wire logic [63:0] col3_rows01,
	input  wire logic [63:0] col3_rows23,
	input  wire logic [63:0] box_min_xy,
	input  wire logic [63:0] box_min_z_max_x,
	input  wire logic [63:0] box_max_yz,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] out_min_xy,
	output logic      [63:0] out_min_z_max_x,
	output logic      [63:0] out_max_yz,
	output logic             result_valid
);
	import aat_pkg::*;

	logic [AAT_STAGES-1:0] vld_q;
	logic [AAT_STAGES-1:0] load;

	// Input unpacking: m[c][r] is column c, row r.
	f32_t m_in   [4][4];
	f32_t bmin_in[3];
	f32_t bmax_in[3];
	logic ok_in;

	// Stage 1
	f32_t t_s1[3], u_s1[3], v_s1[3][3], tr_s1[3];
	f32_t sqa_s1, sqb_s1, sqc_s1, dm1_s1, sqd_s1;
	logic ok_s1;
	// Stage 2
	f32_t lc_s2[3], le_s2[3], v_s2[3][3], tr_s2[3];
	f32_t rs_s2, sqc_s2, sqdm_s2, sqd_s2;
	logic ok_s2;
	// Stage 3: products indexed [row][column]
	f32_t pt_s3[3][3], pu_s3[3][3], tr_s3[3];
	f32_t rs_s3, sqdm_s3, sqd_s3;
	logic ok_s3;
	// Stage 4
	f32_t cen_s4[3], ext_s4[3], pt_s4[3][3], pu_s4[3][3];
	f32_t diff_s4, rsq_s4;
	logic ok_s4;
	// Stage 5
	f32_t cen_s5[3], ext_s5[3], pt_s5[3], pu_s5[3];
	f32_t diff_s5, lims_s5;
	logic ok_s5;
	// Stage 6
	f32_t cen_s6[3], ext_s6[3];
	f32_t diff_s6, lim_s6;
	logic ok_s6;
	// Stage 7
	f32_t wmin_s7[3], wmax_s7[3];
	logic aff_s7;
	logic ok_s7;
	// Output stage
	logic res_ok;

	aat_pipe_ctrl #(
		.Stages(AAT_STAGES)
	) u_ctrl (
		.stage_vld(vld_q),
		.out_stall(out_stall),
		.load     (load)
	);

	assign in_stall  = !load[0];
	assign out_valid = vld_q[AAT_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < AAT_STAGES; k++) begin
				if (load[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		m_in[0][0] = col0_rows01[31:0];
		m_in[0][1] = col0_rows01[63:32];
		m_in[0][2] = col0_rows23[31:0];
		m_in[0][3] = col0_rows23[63:32];
		m_in[1][0] = col1_rows01[31:0];
		m_in[1][1] = col1_rows01[63:32];
		m_in[1][2] = col1_rows23[31:0];
		m_in[1][3] = col1_rows23[63:32];
		m_in[2][0] = col2_rows01[31:0];
		m_in[2][1] = col2_rows01[63:32];
		m_in[2][2] = col2_rows23[31:0];
		m_in[2][3] = col2_rows23[63:32];
		m_in[3][0] = col3_rows01[31:0];
		m_in[3][1] = col3_rows01[63:32];
		m_in[3][2] = col3_rows23[31:0];
		m_in[3][3] = col3_rows23[63:32];
		bmin_in[0] = box_min_xy[31:0];
		bmin_in[1] = box_min_xy[63:32];
		bmin_in[2] = box_min_z_max_x[31:0];
		bmax_in[0] = box_min_z_max_x[63:32];
		bmax_in[1] = box_max_yz[31:0];
		bmax_in[2] = box_max_yz[63:32];
		// Every input must be finite and the local box must not be inverted.
		ok_in = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (!f_isfin(bmin_in[i]) || !f_isfin(bmax_in[i])
					|| !f_le(bmin_in[i], bmax_in[i]))
				ok_in = 1'b0;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!f_isfin(m_in[c][r]))
					ok_in = 1'b0;
			end
		end
	end

	// Stage 1: corner halves, bottom-row squares and d-1.
	always_ff @(posedge clk) begin
		if (load[0]) begin
			for (int i = 0; i < 3; i++) begin
				t_s1[i]  <= f_mul(bmin_in[i], F_HALF);
				u_s1[i]  <= f_mul(bmax_in[i], F_HALF);
				tr_s1[i] <= m_in[3][i];
				for (int c = 0; c < 3; c++)
					v_s1[i][c] <= m_in[c][i];
			end
			sqa_s1 <= f_mul(m_in[0][3], m_in[0][3]);
			sqb_s1 <= f_mul(m_in[1][3], m_in[1][3]);
			sqc_s1 <= f_mul(m_in[2][3], m_in[2][3]);
			dm1_s1 <= f_sub(m_in[3][3], F_ONE);
			sqd_s1 <= f_mul(m_in[3][3], m_in[3][3]);
			ok_s1  <= ok_in;
		end
	end

	// Stage 2: local center and extent.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int i = 0; i < 3; i++) begin
				lc_s2[i] <= f_add(t_s1[i], u_s1[i]);
				le_s2[i] <= f_sub(u_s1[i], t_s1[i]);
				tr_s2[i] <= tr_s1[i];
			end
			v_s2    <= v_s1;
			rs_s2   <= f_add(sqa_s1, sqb_s1);
			sqc_s2  <= sqc_s1;
			sqdm_s2 <= f_mul(dm1_s1, dm1_s1);
			sqd_s2  <= sqd_s1;
			ok_s2   <= ok_s1;
		end
	end

	// Stage 3: matrix times center and absolute matrix times extent.
	always_ff @(posedge clk) begin
		if (load[2]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pt_s3[r][c] <= f_mul(v_s2[r][c], lc_s2[c]);
					pu_s3[r][c] <= f_mul(f_abs(v_s2[r][c]), le_s2[c]);
				end
				tr_s3[r] <= tr_s2[r];
			end
			rs_s3   <= f_add(rs_s2, sqc_s2);
			sqdm_s3 <= sqdm_s2;
			sqd_s3  <= sqd_s2;
			ok_s3   <= ok_s2;
		end
	end

	// Stage 4: column 0 of the sums, bottom-row distance and norm.
	always_ff @(posedge clk) begin
		if (load[3]) begin
			for (int r = 0; r < 3; r++) begin
				cen_s4[r] <= f_add(tr_s3[r], pt_s3[r][0]);
				ext_s4[r] <= f_add(F_ZERO, pu_s3[r][0]);
			end
			pt_s4   <= pt_s3;
			pu_s4   <= pu_s3;
			diff_s4 <= f_add(rs_s3, sqdm_s3);
			rsq_s4  <= f_add(rs_s3, sqd_s3);
			ok_s4   <= ok_s3;
		end
	end

	// Stage 5: column 1 of the sums, clamp of the norm to one.
	always_ff @(posedge clk) begin
		if (load[4]) begin
			for (int r = 0; r < 3; r++) begin
				cen_s5[r] <= f_add(cen_s4[r], pt_s4[r][1]);
				ext_s5[r] <= f_add(ext_s4[r], pu_s4[r][1]);
				pt_s5[r]  <= pt_s4[r][2];
				pu_s5[r]  <= pu_s4[r][2];
			end
			lims_s5 <= f_lt(F_ONE, rsq_s4) ? F_ONE : rsq_s4;
			diff_s5 <= diff_s4;
			ok_s5   <= ok_s4;
		end
	end

	// Stage 6: column 2 of the sums, tolerance scaling.
	always_ff @(posedge clk) begin
		if (load[5]) begin
			for (int r = 0; r < 3; r++) begin
				cen_s6[r] <= f_add(cen_s5[r], pt_s5[r]);
				ext_s6[r] <= f_add(ext_s5[r], pu_s5[r]);
			end
			lim_s6  <= f_mul(F_EPS, lims_s5);
			diff_s6 <= diff_s5;
			ok_s6   <= ok_s5;
		end
	end

	// Stage 7: world corners and the affine decision.
	always_ff @(posedge clk) begin
		if (load[6]) begin
			for (int r = 0; r < 3; r++) begin
				wmin_s7[r] <= f_sub(cen_s6[r], ext_s6[r]);
				wmax_s7[r] <= f_add(cen_s6[r], ext_s6[r]);
			end
			aff_s7 <= f_le(diff_s6, lim_s6);
			ok_s7  <= ok_s6;
		end
	end

	// The world box must be finite and not inverted.
	always_comb begin
		res_ok = ok_s7 && aff_s7;
		for (int r = 0; r < 3; r++) begin
			if (!f_isfin(wmin_s7[r]) || !f_isfin(wmax_s7[r])
					|| !f_le(wmin_s7[r], wmax_s7[r]))
				res_ok = 1'b0;
		end
	end

	// Output stage: invalid results carry the empty box.
	always_ff @(posedge clk) begin
		if (load[7]) begin
			result_valid <= res_ok;
			if (res_ok) begin
				out_min_xy      <= {wmin_s7[1], wmin_s7[0]};
				out_min_z_max_x <= {wmax_s7[0], wmin_s7[2]};
				out_max_yz      <= {wmax_s7[2], wmax_s7[1]};
			end else begin
				out_min_xy      <= {F_POS_INF, F_POS_INF};
				out_min_z_max_x <= {F_NEG_INF, F_POS_INF};
				out_max_yz      <= {F_NEG_INF, F_NEG_INF};
			end
		end
	end

endmodule
`default_nettype wire

[tb/sv/aabb_affine_transform_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_test
// Self-checking bench for the box transform pipeline. Each accepted item is
// run through a bit-exact single-precision model of the center/extent method,
// and every result leaving the block is compared field by field against the
// oldest expected box. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module aabb_affine_transform_test;

	typedef logic [31:0] flt_t;
	typedef logic [63:0] word_t;

	typedef struct {
		word_t min_xy;
		word_t min_z_max_x;
		word_t max_yz;
		logic  ok;
	} world_box_t;

	localparam flt_t K_ONE  = 32'h3F80_0000;
	localparam flt_t K_HALF = 32'h3F00_0000;
	localparam flt_t K_EPS  = 32'h2B8C_BCCC;
	localparam flt_t K_PINF = 32'h7F80_0000;
	localparam flt_t K_NINF = 32'hFF80_0000;
	localparam flt_t K_QNAN = 32'h7FC0_0000;
	localparam int   N_RANDOM = 500;
	localparam int   DRAIN_CYCLES = 20;

	// Single-precision arithmetic is done in double precision and rounded
	// once to single. Double carries more than twice the single significand
	// plus two bits, so this double rounding equals a single correct rounding.
	function automatic real flt_to_real(input flt_t b);
		real v;
		if (b[30:23] == 8'hFF) begin
			if (b[22:0] != 0)
				return $bitstoreal({1'b0, 11'h7FF, 1'b1, 51'd0});
			return $bitstoreal({b[31], 11'h7FF, 52'd0});
		end
		if (b[30:23] == 8'd0) begin
			v = $itor(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
			return b[31] ? -v : v;
		end
		return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0});
	endfunction

	function automatic flt_t real_to_flt(input real x);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] r;
		logic        s;
		int          e;
		int          eb;
		int          sh;
		d = $realtobits(x);
		s = d[63];
		e = int'(d[62:52]);
		if (e == 2047)
			return (d[51:0] != 0) ? K_QNAN : {s, 8'hFF, 23'd0};
		if (e == 0)
			return {s, 31'd0};
		eb = e - 1023 + 127;
		m  = {11'd0, 1'b1, d[51:0]};
		sh = (eb >= 1) ? 29 : 29 + 1 - eb;
		if (sh > 54)
			return {s, 31'd0};
		q    = m >> sh;
		rem  = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if ((rem > half) || ((rem == half) && q[0]))
			q = q + 64'd1;
		// A rounding carry walks into the exponent field on its own.
		r = (64'(((eb >= 1) ? eb : 1) - 1) << 23) + q;
		if (r >= 64'h7F80_0000)
			return {s, 8'hFF, 23'd0};
		return {s, r[30:0]};
	endfunction

	function automatic flt_t fmul(input flt_t a, input flt_t b);
		return real_to_flt(flt_to_real(a) * flt_to_real(b));
	endfunction

	function automatic flt_t fadd(input flt_t a, input flt_t b);
		return real_to_flt(flt_to_real(a) + flt_to_real(b));
	endfunction

	function automatic flt_t fsub(input flt_t a, input flt_t b);
		return real_to_flt(flt_to_real(a) - flt_to_real(b));
	endfunction

	function automatic logic finite(input flt_t a);
		return a[30:23] != 8'hFF;
	endfunction

	function automatic logic ordered(input flt_t lo, input flt_t hi);
		return finite(lo) && finite(hi) && (flt_to_real(lo) <= flt_to_real(hi));
	endfunction

	// Computes the world box for one item; fields are in port order.
	function automatic world_box_t transform_box(input word_t f [11]);
		flt_t m [16];
		flt_t lmin [3];
		flt_t lmax [3];
		flt_t lc [3];
		flt_t le [3];
		flt_t wmin [3];
		flt_t wmax [3];
		flt_t t;
		flt_t u;
		flt_t row_sq;
		flt_t diff;
		flt_t lim;
		flt_t cen;
		flt_t ext;
		flt_t v;
		logic good;
		world_box_t res;
		good = 1'b1;
		for (int i = 0; i < 8; i++) begin
			m[2 * i]     = f[i][31:0];
			m[2 * i + 1] = f[i][63:32];
		end
		lmin[0] = f[8][31:0];
		lmin[1] = f[8][63:32];
		lmin[2] = f[9][31:0];
		lmax[0] = f[9][63:32];
		lmax[1] = f[10][31:0];
		lmax[2] = f[10][63:32];
		for (int i = 0; i < 3; i++)
			if (!ordered(lmin[i], lmax[i]))
				good = 1'b0;
		for (int i = 0; i < 16; i++)
			if (!finite(m[i]))
				good = 1'b0;
		if (good) begin
			// The bottom row must be (0, 0, 0, 1) up to a relative tolerance.
			row_sq = fadd(fmul(m[3], m[3]), fmul(m[7], m[7]));
			row_sq = fadd(row_sq, fmul(m[11], m[11]));
			t      = fsub(m[15], K_ONE);
			diff   = fadd(row_sq, fmul(t, t));
			row_sq = fadd(row_sq, fmul(m[15], m[15]));
			lim    = (flt_to_real(K_ONE) < flt_to_real(row_sq)) ? K_ONE : row_sq;
			lim    = fmul(K_EPS, lim);
			if (!(flt_to_real(diff) <= flt_to_real(lim)))
				good = 1'b0;
		end
		if (good) begin
			for (int i = 0; i < 3; i++) begin
				t     = fmul(lmin[i], K_HALF);
				u     = fmul(lmax[i], K_HALF);
				lc[i] = fadd(t, u);
				le[i] = fsub(u, t);
			end
			for (int r = 0; r < 3; r++) begin
				cen = m[12 + r];
				ext = 32'h0000_0000;
				for (int c = 0; c < 3; c++) begin
					v   = m[c * 4 + r];
					cen = fadd(cen, fmul(v, lc[c]));
					ext = fadd(ext, fmul({1'b0, v[30:0]}, le[c]));
				end
				wmin[r] = fsub(cen, ext);
				wmax[r] = fadd(cen, ext);
				if (!ordered(wmin[r], wmax[r]))
					good = 1'b0;
			end
		end
		if (good) begin
			res.min_xy      = {wmin[1], wmin[0]};
			res.min_z_max_x = {wmax[0], wmin[2]};
			res.max_yz      = {wmax[2], wmax[1]};
			res.ok          = 1'b1;
		end else begin
			res.min_xy      = {K_PINF, K_PINF};
			res.min_z_max_x = {K_NINF, K_PINF};
			res.max_yz      = {K_NINF, K_NINF};
			res.ok          = 1'b0;
		end
		return res;
	endfunction

	// Holds the boxes that the block still owes, oldest first.
	class box_scoreboard;
		world_box_t pending [$];
		int         errors = 0;

		task report(input string what);
			$display("ERROR at %0t: %s", $time, what);
			errors++;
		endtask

		function void note_item(input word_t f [11]);
			pending.push_back(transform_box(f));
		endfunction

		task check_result(input word_t a, input word_t b, input word_t c, input logic ok);
			world_box_t e;
			if (pending.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				e = pending.pop_front();
				if (a !== e.min_xy)
					report($sformatf("out_min_xy %h, expected %h", a, e.min_xy));
				if (b !== e.min_z_max_x)
					report($sformatf("out_min_z_max_x %h, expected %h", b, e.min_z_max_x));
				if (c !== e.max_yz)
					report($sformatf("out_max_yz %h, expected %h", c, e.max_yz));
				if (ok !== e.ok)
					report($sformatf("result_valid %b, expected %b", ok, e.ok));
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	logic  out_valid;
	logic  out_stall;
	word_t fld [11];
	word_t out_min_xy;
	word_t out_min_z_max_x;
	word_t out_max_yz;
	logic  result_valid;
	logic  calm;

	box_scoreboard boxes;

	aabb_affine_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.col0_rows01(fld[0]),
		.col0_rows23(fld[1]),
		.col1_rows01(fld[2]),
		.col1_rows23(fld[3]),
		.col2_rows01(fld[4]),
		.col2_rows23(fld[5]),
		.col3_rows01(fld[6]),
		.col3_rows23(fld[7]),
		.box_min_xy(fld[8]),
		.box_min_z_max_x(fld[9]),
		.box_max_yz(fld[10]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_min_xy(out_min_xy),
		.out_min_z_max_x(out_min_z_max_x),
		.out_max_yz(out_max_yz),
		.result_valid(result_valid)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A moderate finite float with random sign and fraction.
	function automatic flt_t rand_flt();
		flt_t b;
		b = $urandom;
		b[30:23] = 8'($urandom_range(107, 147));
		if ($urandom_range(0, 15) == 0)
			b[30:0] = 31'd0;
		return b;
	endfunction

	// One of the awkward values: zeros, subnormals, extremes, infinities, NaN.
	function automatic flt_t odd_flt();
		case ($urandom_range(0, 7))
			0: return {$urandom_range(0, 1) == 1, 31'd0};
			1: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
			2: return {$urandom_range(0, 1) == 1, 8'hFE, 23'($urandom)};
			3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
			4: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'd1};
			5: return 32'($urandom);
			default: return rand_flt();
		endcase
	endfunction

	// Builds an item: an affine matrix over a well-ordered box, then spoils it
	// in one of several ways for a share of the items.
	task automatic make_item(output word_t f [11]);
		flt_t m [16];
		flt_t lo [3];
		flt_t hi [3];
		flt_t a;
		flt_t b;
		int   kind;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 16; i++)
			m[i] = rand_flt();
		m[3] = 32'd0;
		m[7] = 32'd0;
		m[11] = 32'd0;
		m[15] = K_ONE;
		for (int i = 0; i < 3; i++) begin
			a = rand_flt();
			b = rand_flt();
			if (flt_to_real(a) <= flt_to_real(b)) begin
				lo[i] = a;
				hi[i] = b;
			end else begin
				lo[i] = b;
				hi[i] = a;
			end
		end
		if (kind < 8) begin
			// A bottom row that is only nearly affine, on either side of the limit.
			m[$urandom_range(0, 3) * 4 + 3] = {1'($urandom), 8'($urandom_range(90, 110)),
				23'($urandom)};
		end else if (kind < 14) begin
			m[15] = {1'b0, 8'd127, 23'($urandom_range(0, 3))};
		end else if (kind < 20) begin
			m[$urandom_range(0, 15)] = odd_flt();
		end else if (kind < 26) begin
			if ($urandom_range(0, 1) == 1)
				lo[$urandom_range(0, 2)] = odd_flt();
			else
				hi[$urandom_range(0, 2)] = odd_flt();
		end else if (kind < 30) begin
			a = lo[0];
			lo[0] = hi[0];
			hi[0] = a;
		end else if (kind < 34) begin
			m[$urandom_range(0, 2) * 4 + $urandom_range(0, 2)] = {1'($urandom), 8'hFE,
				23'($urandom)};
		end else if (kind < 37) begin
			lo[1] = hi[1];
		end
		for (int i = 0; i < 8; i++)
			f[i] = {m[2 * i + 1], m[2 * i]};
		f[8]  = {lo[1], lo[0]};
		f[9]  = {hi[0], lo[2]};
		f[10] = {hi[2], hi[1]};
		if (kind >= 95)
			for (int i = 0; i < 11; i++)
				f[i] = {32'($urandom), 32'($urandom)};
	endtask

	// Presents one item and holds it until the block takes it.
	task automatic send_item(input word_t f [11]);
		for (int i = 0; i < 11; i++)
			fld[i] <= f[i];
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		boxes.note_item(f);
	endtask

	task automatic send_with_gap(input word_t f [11]);
		int gap;
		send_item(f);
		if (!calm && ($urandom_range(0, 3) == 0)) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	// Sends an item built from the given matrix over the given box.
	task automatic directed_item(input flt_t m [16], input flt_t lo [3], input flt_t hi [3]);
		word_t f [11];
		for (int i = 0; i < 8; i++)
			f[i] = {m[2 * i + 1], m[2 * i]};
		f[8]  = {lo[1], lo[0]};
		f[9]  = {hi[0], lo[2]};
		f[10] = {hi[2], hi[1]};
		send_with_gap(f);
	endtask

	// The receiving side: check each accepted result, then pick the next stall.
	int stall_left;
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				boxes.check_result(out_min_xy, out_min_z_max_x, out_max_yz, result_valid);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && ($urandom_range(0, 5) == 0)) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("aabb_affine_transform: mismatch");
		$finish;
	end

	initial begin
		flt_t  m [16];
		flt_t  lo [3];
		flt_t  hi [3];
		word_t f [11];
		boxes    = new();
		calm     = 1'b0;
		in_valid = 1'b0;
		for (int i = 0; i < 11; i++)
			fld[i] = 64'd0;
		arst_n = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: identity over the box from -1 to 1, then one special case each.
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? K_ONE : 32'd0;
		for (int i = 0; i < 3; i++) begin
			lo[i] = 32'hBF80_0000;
			hi[i] = K_ONE;
		end
		directed_item(m, lo, hi);
		// A degenerate box of one point, with signed zeros.
		lo = '{32'h8000_0000, 32'd0, 32'd0};
		hi = '{32'd0, 32'h8000_0000, 32'd0};
		directed_item(m, lo, hi);
		// Subnormal corners.
		lo = '{32'h8000_0001, 32'h807F_FFFF, 32'd1};
		hi = '{32'd1, 32'h007F_FFFF, 32'd2};
		directed_item(m, lo, hi);
		// Largest finite corners; halving first keeps center and extent finite.
		lo = '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'd0};
		hi = '{32'h7F7F_FFFF, 32'h7F7F_FFFF, K_ONE};
		directed_item(m, lo, hi);
		lo = '{32'hBF80_0000, 32'hBF80_0000, 32'hBF80_0000};
		hi = '{K_ONE, K_ONE, K_ONE};
		// A largest finite matrix entry gives the largest finite extent.
		m[0] = 32'h7F7F_FFFF;
		directed_item(m, lo, hi);
		m[0] = K_ONE;
		// Infinity and NaN in the matrix and in the box.
		m[5] = K_PINF;
		directed_item(m, lo, hi);
		m[5] = K_ONE;
		m[12] = K_QNAN;
		directed_item(m, lo, hi);
		m[12] = 32'd0;
		lo[2] = K_NINF;
		directed_item(m, lo, hi);
		lo[2] = 32'hBF80_0000;
		hi[1] = 32'hFFC0_0001;
		directed_item(m, lo, hi);
		hi[1] = K_ONE;
		// An inverted box.
		lo[1] = 32'h4000_0000;
		directed_item(m, lo, hi);
		lo[1] = 32'hBF80_0000;
		// Bottom rows: projective, scaled, tiny off-diagonal, all zero.
		m[3] = K_HALF;
		directed_item(m, lo, hi);
		m[3] = 32'd0;
		m[15] = 32'h4000_0000;
		directed_item(m, lo, hi);
		m[15] = K_ONE;
		m[7] = 32'h3400_0000;
		directed_item(m, lo, hi);
		m[7] = 32'h3580_0000;
		directed_item(m, lo, hi);
		m[7] = 32'd0;
		m[15] = 32'd0;
		directed_item(m, lo, hi);
		m[15] = K_ONE;
		// Negative scales and a translation.
		m[0] = 32'hC040_0000;
		m[6] = 32'hBF00_0000;
		m[9] = 32'h4120_0000;
		m[13] = 32'hC2C8_0000;
		directed_item(m, lo, hi);
		// All ones and all zeros in every field.
		for (int i = 0; i < 11; i++)
			f[i] = '1;
		send_with_gap(f);
		for (int i = 0; i < 11; i++)
			f[i] = '0;
		send_with_gap(f);

		// Random part; the last stretch runs with no idling on either side.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - N_RANDOM / 8)
				calm = 1'b1;
			make_item(f);
			send_with_gap(f);
		end
		in_valid <= 1'b0;

		while (boxes.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (boxes.errors == 0)
			$display("aabb_affine_transform: match");
		else
			$display("aabb_affine_transform: mismatch");
		$finish;
	end

endmodule
